/* sv/usd_pkg.sv */
// Shared types, constants and decode functions for the UTF-8 display sanitizer.
package usd_pkg;

    localparam int LIMIT_BITS  = 16;
    localparam int CNT_W       = LIMIT_BITS + 1;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_MODE     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_OUTPUT_BYTES = 8'd1;

    localparam logic [7:0] REPL_B0   = 8'hEF;
    localparam logic [7:0] REPL_B1   = 8'hBF;
    localparam logic [7:0] REPL_B2   = 8'hBD;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] TOP_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF4;
    localparam logic [7:0] LEAD_SURR = 8'hED;
    localparam logic [7:0] FOL_A0    = 8'hA0;
    localparam logic [7:0] FOL_9F    = 8'h9F;
    localparam logic [7:0] FOL_90    = 8'h90;
    localparam logic [7:0] FOL_8F    = 8'h8F;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

    typedef struct packed {
        logic                  display_mode;
        logic [LIMIT_BITS-1:0] max_output_bytes;
    } t_cfg;

    // One queued transaction: reps replacement pieces, then an optional valid
    // sequence, then the end-of-string work when last is set.
    typedef struct packed {
        logic [2:0]      reps;
        logic            has_piece;
        logic [2:0]      plen;
        logic [3:0][7:0] pbytes;
        logic            last;
    } t_entry;

    function automatic logic [2:0] seq_len(input logic [7:0] lead);
        logic [2:0] len;
        len = 3'd0;
        if (lead < CONT_TAG)                             len = 3'd1;
        else if (lead >= LEAD2_LO && lead <= LEAD2_HI)   len = 3'd2;
        else if (lead >= LEAD3_LO && lead <= LEAD3_HI)   len = 3'd3;
        else if (lead >= LEAD4_LO && lead <= LEAD4_HI)   len = 3'd4;
        return len;
    endfunction

    function automatic logic follower_ok(input logic [7:0] lead, input logic [1:0] idx,
                                         input logic [7:0] b);
        logic ok;
        ok = ((b & TOP_MASK) == CONT_TAG);
        if (idx == 2'd1) begin
            if (lead == LEAD3_LO  && b < FOL_A0) ok = 1'b0;
            if (lead == LEAD_SURR && b > FOL_9F) ok = 1'b0;
            if (lead == LEAD4_LO  && b < FOL_90) ok = 1'b0;
            if (lead == LEAD4_HI  && b > FOL_8F) ok = 1'b0;
        end
        return ok;
    endfunction

endpackage

/* sv/utf8_display_sanitizer_core.sv */
// An accepted byte is written into the piece queue, and its first output byte is then registered at the output.
// Throughput: one input byte per cycle while o_stall is low; the back end sends one output
// byte per cycle while i_stall is low, and a piece dropped by truncation sends no byte.
// A four-entry piece queue absorbs expansion; o_stall rises while it is full.
// Reset (synchronous, active low) clears the hold, counters, queue and output, and
// sets plain mode with a limit of 65535; no clearing pass is needed.
module utf8_display_sanitizer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  usd_pkg::t_in_item              i_data,
    output logic                           o_stall,
    output logic                           o_valid,
    output usd_pkg::t_out_item             o_data,
    input  logic                           i_stall,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [usd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [usd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import usd_pkg::*;

    t_cfg   r_cfg;
    logic   push;
    logic   full;
    logic   pop;
    logic   q_valid;
    t_entry push_entry;
    t_entry q_entry;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.display_mode     <= 1'b0;
            r_cfg.max_output_bytes <= '1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_DISPLAY_MODE:     r_cfg.display_mode     <= i_cfg_data[0];
                REG_MAX_OUTPUT_BYTES: r_cfg.max_output_bytes <= i_cfg_data[LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    usd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_full  (full),
        .o_stall (o_stall),
        .o_push  (push),
        .o_entry (push_entry)
    );

    usd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    usd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .i_stall   (i_stall)
    );

endmodule

/* sv/usd_front.sv */
// Front end: accepts bytes, tracks the unfinished sequence, queues pieces.
module usd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  usd_pkg::t_in_item i_data,
    input  logic              i_full,
    output logic              o_stall,
    output logic              o_push,
    output usd_pkg::t_entry   o_entry
);
    import usd_pkg::*;

    logic [2:0][7:0] r_held;
    logic [2:0][7:0] n_held;
    logic [1:0]      r_hcnt;
    logic [1:0]      n_hcnt;
    logic [2:0]      lead_len;
    logic [2:0]      byte_len;
    logic            accept;
    t_entry          ent;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        n_held   = r_held;
        n_hcnt   = r_hcnt;
        ent      = '0;
        lead_len = seq_len(r_held[0]);
        byte_len = seq_len(i_data.in_byte);
        if (r_hcnt != 2'd0 && follower_ok(r_held[0], r_hcnt, i_data.in_byte)) begin
            if (({1'b0, r_hcnt} + 3'd1) >= lead_len) begin
                ent.has_piece      = 1'b1;
                ent.plen           = lead_len;
                ent.pbytes[0]      = r_held[0];
                ent.pbytes[1]      = r_held[1];
                ent.pbytes[2]      = r_held[2];
                ent.pbytes[r_hcnt] = i_data.in_byte;
                n_hcnt             = 2'd0;
            end else begin
                n_held[r_hcnt] = i_data.in_byte;
                n_hcnt         = r_hcnt + 2'd1;
            end
        end else begin
            // flush what is held, then read the byte again as a lead
            ent.reps = {1'b0, r_hcnt};
            n_hcnt   = 2'd0;
            if (byte_len == 3'd0) begin
                ent.reps = ent.reps + 3'd1;
            end else if (byte_len == 3'd1) begin
                ent.has_piece = 1'b1;
                ent.plen      = 3'd1;
                ent.pbytes[0] = i_data.in_byte;
            end else begin
                n_held[0] = i_data.in_byte;
                n_hcnt    = 2'd1;
            end
        end
        if (i_data.in_last && n_hcnt != 2'd0) begin
            ent.reps = ent.reps + {1'b0, n_hcnt};
            n_hcnt   = 2'd0;
        end
        ent.last = i_data.in_last;
    end

    assign o_entry = ent;
    assign o_push  = accept && (ent.reps != 3'd0 || ent.has_piece || ent.last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hcnt <= 2'd0;
        end else if (accept) begin
            r_hcnt <= n_hcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

endmodule

/* sv/usd_fifo.sv */
// Short queue of piece transactions between the front and back ends.
module usd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  usd_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output usd_pkg::t_entry o_entry
);
    import usd_pkg::*;

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wptr;
    logic [QPTR_W-1:0]   r_rptr;
    logic [QCNT_W-1:0]   r_cnt;
    logic [QCNT_W-1:0]   n_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rptr];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) n_cnt = r_cnt + 1'b1;
        else if (!i_push && i_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + 1'b1;
            if (i_pop)  r_rptr <= r_rptr + 1'b1;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

endmodule

/* sv/usd_back.sv */
// Back end: expands queued pieces into bytes, filters, truncates, drives output.
module usd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  usd_pkg::t_cfg      i_cfg,
    input  logic               i_q_valid,
    input  usd_pkg::t_entry    i_q_entry,
    output logic               o_pop,
    output logic               o_valid,
    output usd_pkg::t_out_item o_data,
    input  logic               i_stall
);
    import usd_pkg::*;

    typedef enum logic [1:0] {
        PH_ELEM = 2'b01,
        PH_DOTS = 2'b10
    } t_bk_phase;

    t_bk_phase         r_phase;
    logic [2:0]        r_e;
    logic [1:0]        r_bidx;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_trunc;
    logic              r_ov;
    t_out_item         r_out;

    logic              is_dots;
    logic              is_rep;
    logic              filt;
    logic [2:0]        psize;
    logic [2:0]        size;
    logic [CNT_W-1:0]  sum;
    logic              start;
    logic              drop;
    logic              elem_done;
    logic [2:0]        next_e;
    logic              next_exists;
    logic              trunc_nxt;
    logic              to_dots;
    logic              pop;
    logic              go;
    logic [7:0]        obyte;

    assign is_dots = (r_phase == PH_DOTS);
    assign is_rep  = (r_e < i_q_entry.reps);

    // display-mode control filter: C0 controls, DEL, and C2 80..9F
    assign filt = i_cfg.display_mode &&
                  ((i_q_entry.plen == 3'd1 &&
                    (i_q_entry.pbytes[0] < CH_SPACE || i_q_entry.pbytes[0] == CH_DEL)) ||
                   (i_q_entry.plen == 3'd2 && i_q_entry.pbytes[0] == LEAD2_LO &&
                    i_q_entry.pbytes[1] < FOL_A0));
    assign psize = filt ? 3'd1 : i_q_entry.plen;
    assign size  = (is_dots || is_rep) ? 3'd3 : psize;

    assign sum   = r_cnt + CNT_W'(size);
    assign start = (r_bidx == 2'd0) && !is_dots;
    assign drop  = start && (r_trunc ||
                   (i_cfg.display_mode && (sum > {1'b0, i_cfg.max_output_bytes})));
    assign elem_done = drop || ({1'b0, r_bidx} == (size - 3'd1));

    assign next_e      = r_e + 3'd1;
    assign next_exists = (next_e < i_q_entry.reps) ||
                         (next_e == i_q_entry.reps && i_q_entry.has_piece);
    assign trunc_nxt   = r_trunc || drop;
    assign to_dots     = !is_dots && !next_exists && i_q_entry.last && trunc_nxt;
    assign pop         = elem_done && (is_dots || (!next_exists && !to_dots));

    assign go    = i_q_valid && (!r_ov || !i_stall);
    assign o_pop = go && pop;

    always_comb begin
        obyte = CH_DOT;
        if (!is_dots) begin
            if (is_rep) begin
                case (r_bidx)
                    2'd0:    obyte = REPL_B0;
                    2'd1:    obyte = REPL_B1;
                    default: obyte = REPL_B2;
                endcase
            end else begin
                obyte = filt ? CH_QMARK : i_q_entry.pbytes[r_bidx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_ELEM;
            r_e     <= 3'd0;
            r_bidx  <= 2'd0;
            r_cnt   <= '0;
            r_trunc <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (go) begin
                if (start && !drop && i_cfg.display_mode) r_cnt <= sum;
                r_trunc <= trunc_nxt;
                if (elem_done) begin
                    r_bidx <= 2'd0;
                    if (pop) begin
                        r_phase <= PH_ELEM;
                        r_e     <= 3'd0;
                        if (i_q_entry.last) begin
                            r_cnt   <= '0;
                            r_trunc <= 1'b0;
                        end
                    end else if (to_dots) begin
                        r_phase <= PH_DOTS;
                    end else begin
                        r_e <= next_e;
                    end
                end else begin
                    r_bidx <= r_bidx + 2'd1;
                end
            end
            if (go && !drop) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && !drop) begin
            r_out.out_byte <= obyte;
            r_out.out_last <= pop && i_q_entry.last;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

/* sv/usd_checker.sv */
// Port-level checks for the sanitizer core, bound to the top level.
module usd_port_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_valid,
    input  usd_pkg::t_out_item o_data,
    input  logic               i_stall
);
    import usd_pkg::*;

    // hold a stalled output transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output transaction changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // never send bytes that cannot appear in well-formed UTF-8
    a_no_bad_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.out_byte != 8'hC0 && o_data.out_byte != 8'hC1 &&
                    o_data.out_byte < 8'hF5)
        else $error("invalid UTF-8 byte on output");

    // a string never ends on a lead byte
    a_last_not_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.out_last |-> (o_data.out_byte & TOP_MASK) != TOP_MASK)
        else $error("string closed on a lead byte");

endmodule

bind utf8_display_sanitizer_core usd_port_checker u_usd_checker (.*);

/* dv/usd_checker.sv */
// Checker for the UTF-8 display sanitizer: predicts output bytes and compares them.
module usd_checker
    import usd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  t_in_item               i_in_data,
    input  logic                   i_in_stall,
    input  logic                   i_out_valid,
    input  t_out_item              i_out_data,
    input  logic                   i_out_stall,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_errors,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]  held_seq [3];
    int unsigned held_cnt;
    int unsigned sent_count;
    bit          cut_off;
    bit          disp_mode;
    int unsigned byte_limit;
    int unsigned step_bytes;
    t_out_item   expected_bytes [$];
    t_out_item   want;
    int          fail_count = 0;

    assign o_errors = fail_count;

    function automatic int unsigned lead_len(logic [7:0] b);
        int unsigned n;
        n = 0;
        if (b < CONT_TAG)                        n = 1;
        else if (b inside {[LEAD2_LO:LEAD2_HI]}) n = 2;
        else if (b inside {[LEAD3_LO:LEAD3_HI]}) n = 3;
        else if (b inside {[LEAD4_LO:LEAD4_HI]}) n = 4;
        return n;
    endfunction

    // Second byte of E0, ED, F0 and F4 sequences has a narrowed range.
    function automatic bit cont_fits(logic [7:0] lead, int unsigned pos, logic [7:0] b);
        bit ok;
        ok = (b[7:6] == 2'b10);
        if (ok && pos == 1) begin
            case (lead)
                LEAD3_LO:  ok = (b >= FOL_A0);
                LEAD_SURR: ok = (b <= FOL_9F);
                LEAD4_LO:  ok = (b >= FOL_90);
                LEAD4_HI:  ok = (b <= FOL_8F);
                default:   ok = 1'b1;
            endcase
        end
        return ok;
    endfunction

    function automatic void expect_byte(logic [7:0] b);
        t_out_item item;
        item.out_byte = b;
        item.out_last = 1'b0;
        expected_bytes.push_back(item);
        step_bytes++;
    endfunction

    function automatic void emit_piece(logic [3:0][7:0] p, int unsigned len, bit ok);
        logic [3:0][7:0] piece;
        int unsigned     size;
        int unsigned     i;
        piece = p;
        size  = len;
        if (!ok) begin
            piece[0] = REPL_B0;
            piece[1] = REPL_B1;
            piece[2] = REPL_B2;
            size = 3;
        end else if (disp_mode) begin
            if (len == 1 && (p[0] < CH_SPACE || p[0] == CH_DEL)) begin
                piece[0] = CH_QMARK;
                size = 1;
            end else if (len == 2 && p[0] == LEAD2_LO && p[1] < FOL_A0) begin
                piece[0] = CH_QMARK;
                size = 1;
            end
        end
        if (cut_off) return;
        if (disp_mode) begin
            if (sent_count + size > byte_limit) begin
                cut_off = 1'b1;
                return;
            end
            sent_count += size;
        end
        for (i = 0; i < size; i++) expect_byte(piece[i]);
    endfunction

    function automatic void flush_held();
        int unsigned i;
        for (i = 0; i < held_cnt; i++) emit_piece('0, 1, 1'b0);
        held_cnt = 0;
    endfunction

    function automatic void sanitize_byte(logic [7:0] b, logic closes);
        logic [3:0][7:0] seq;
        int unsigned     n;
        bit              taken;
        t_out_item       tail;
        step_bytes = 0;
        taken = 1'b0;
        if (held_cnt != 0) begin
            n = lead_len(held_seq[0]);
            if (cont_fits(held_seq[0], held_cnt, b)) begin
                taken = 1'b1;
                if (held_cnt + 1 >= n) begin
                    seq = '0;
                    seq[0] = held_seq[0];
                    seq[1] = held_seq[1];
                    seq[2] = held_seq[2];
                    seq[held_cnt] = b;
                    emit_piece(seq, n, 1'b1);
                    held_cnt = 0;
                end else begin
                    held_seq[held_cnt] = b;
                    held_cnt++;
                end
            end else begin
                // reject the partial sequence, then read the byte again as a lead
                flush_held();
            end
        end
        if (!taken) begin
            n = lead_len(b);
            seq = '0;
            seq[0] = b;
            if (n == 0) begin
                emit_piece(seq, 1, 1'b0);
            end else if (n == 1) begin
                emit_piece(seq, 1, 1'b1);
            end else begin
                held_seq[0] = b;
                held_cnt = 1;
            end
        end
        if (closes) begin
            flush_held();
            if (cut_off) repeat (3) expect_byte(CH_DOT);
            cut_off = 1'b0;
            sent_count = 0;
            if (step_bytes != 0) begin
                tail = expected_bytes.pop_back();
                tail.out_last = 1'b1;
                expected_bytes.push_back(tail);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_seq[0] = '0;
            held_seq[1] = '0;
            held_seq[2] = '0;
            held_cnt   = 0;
            sent_count = 0;
            cut_off    = 1'b0;
            disp_mode  = 1'b0;
            byte_limit = {LIMIT_BITS{1'b1}};
            expected_bytes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_DISPLAY_MODE) begin
                    disp_mode = i_cfg_data[0];
                end else if (i_cfg_index == REG_MAX_OUTPUT_BYTES) begin
                    byte_limit = i_cfg_data[LIMIT_BITS-1:0];
                end
            end
            if (i_in_valid && !i_in_stall) begin
                sanitize_byte(i_in_data.in_byte, i_in_data.in_last);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected output byte %02h last %0b, none expected",
                             $time, i_out_data.out_byte, i_out_data.out_last);
                    fail_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out_data.out_byte !== want.out_byte ||
                        i_out_data.out_last !== want.out_last) begin
                        $display("%0t: output mismatch: expected %02h last %0b, got %02h last %0b",
                                 $time, want.out_byte, want.out_last,
                                 i_out_data.out_byte, i_out_data.out_last);
                        fail_count++;
                    end
                end
            end
        end
        o_pending <= expected_bytes.size();
    end

endmodule

/* dv/tb_top.sv */
// Testbench top for the UTF-8 display sanitizer: clock, reset, stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import usd_pkg::*;

    localparam int ITEM_TARGET = 270;
    localparam int CALM_ITEMS  = 40;
    localparam int DRAIN       = 12;

    localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 8'hFF;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_data   = '0;
    logic                  in_stall;
    logic                  out_valid;
    t_out_item             out_data;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int          errors;
    int          pending;
    logic [15:0] cyc        = '0;
    int          sink_burst = 0;
    bit          calm       = 1'b0;
    int unsigned sent       = 0;
    logic [7:0]  text_q [$];

    always #1 clk = ~clk;

    utf8_display_sanitizer_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .i_data      (in_data),
        .o_stall     (in_stall),
        .o_valid     (out_valid),
        .o_data      (out_data),
        .i_stall     (out_stall),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    usd_checker u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .i_in_stall  (in_stall),
        .i_out_valid (out_valid),
        .i_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always @(posedge clk) cyc <= cyc + 1'b1;

    // Output backpressure in bursts, only in alternating windows.
    always @(posedge clk) begin
        if (calm || !rst_n) begin
            out_stall  <= 1'b0;
            sink_burst <= 0;
        end else if (sink_burst != 0) begin
            out_stall  <= 1'b1;
            sink_burst <= sink_burst - 1;
        end else begin
            out_stall <= 1'b0;
            if (cyc[8] && $urandom_range(0, 5) == 0) sink_burst <= $urandom_range(1, 12);
        end
    end

    initial begin
        #400us;
        $display("tb: failure");
        $finish;
    end

    // Leaves valid high; the caller drops it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic send_text(input bit closes);
        int unsigned k;
        for (k = 0; k < text_q.size(); k++) begin
            if (!calm && cyc[7] && $urandom_range(0, 4) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= '{in_byte: text_q[k], in_last: closes && (k == text_q.size() - 1)};
            @(posedge clk);
            while (in_stall) @(posedge clk);
            sent++;
        end
        text_q.delete();
    endtask

    // Wait until every expected byte is out, then let the back end go quiet.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    function automatic void add_code_point(int unsigned cp);
        logic [20:0] c;
        c = cp[20:0];
        if (cp < 'h80) begin
            text_q.push_back({1'b0, c[6:0]});
        end else if (cp < 'h800) begin
            text_q.push_back({3'b110, c[10:6]});
            text_q.push_back({2'b10, c[5:0]});
        end else if (cp < 'h10000) begin
            text_q.push_back({4'b1110, c[15:12]});
            text_q.push_back({2'b10, c[11:6]});
            text_q.push_back({2'b10, c[5:0]});
        end else begin
            text_q.push_back({5'b11110, c[20:18]});
            text_q.push_back({2'b10, c[17:12]});
            text_q.push_back({2'b10, c[11:6]});
            text_q.push_back({2'b10, c[5:0]});
        end
    endfunction

    function automatic int unsigned pick_code_point();
        int unsigned cp;
        case ($urandom_range(0, 5))
            0: cp = $urandom_range(0, 'h7F);
            1: cp = $urandom_range('h80, 'h9F);
            2: cp = $urandom_range('h80, 'h7FF);
            3: begin
                cp = $urandom_range('h800, 'hFFFF);
                // skip the surrogate block
                if (cp >= 'hD800 && cp <= 'hDFFF) cp -= 'h800;
            end
            4: cp = $urandom_range('h10000, 'h10FFFF);
            default: begin
                case ($urandom_range(0, 7))
                    0: cp = 'h7F;
                    1: cp = 'h800;
                    2: cp = 'hD7FF;
                    3: cp = 'hE000;
                    4: cp = 'hFFFF;
                    5: cp = 'h10000;
                    6: cp = 'h10FFFF;
                    default: cp = 'h7FF;
                endcase
            end
        endcase
        return cp;
    endfunction

    // Mostly well-formed text, with stray bytes, cut sequences and bad followers.
    function automatic void build_string();
        int unsigned pieces, k, base_n, cut;
        pieces = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 8);
        for (k = 0; k < pieces; k++) begin
            case ($urandom_range(0, 9))
                7: text_q.push_back(8'($urandom_range(0, 255)));
                8: begin
                    base_n = text_q.size();
                    add_code_point($urandom_range('h80, 'h10FFFF));
                    cut = $urandom_range(1, text_q.size() - base_n - 1);
                    repeat (cut) void'(text_q.pop_back());
                end
                9: begin
                    text_q.push_back(8'($urandom_range('hC0, 'hF7)));
                    repeat ($urandom_range(1, 3)) begin
                        if ($urandom_range(0, 3) == 0) text_q.push_back(8'($urandom_range(0, 255)));
                        else text_q.push_back(8'($urandom_range('h80, 'hBF)));
                    end
                end
                default: add_code_point(pick_code_point());
            endcase
        end
    endfunction

    task automatic reconfigure(input int phase);
        logic [CFG_DATA_W-1:0] mode_word, limit_word;
        int                    pick;
        mode_word = 16'($urandom_range(0, 65535));
        pick = (phase < 2) ? phase : $urandom_range(0, 4);
        case (pick)
            0: limit_word = '0;
            1: limit_word = '1;
            2: limit_word = 16'($urandom_range(1, 12));
            3: limit_word = 16'($urandom_range(13, 60));
            default: limit_word = 16'($urandom_range(0, 65535));
        endcase
        if (phase < 2) mode_word[0] = 1'b1;
        if ($urandom_range(0, 1) == 0) begin
            write_reg(REG_DISPLAY_MODE, mode_word);
            write_reg(REG_MAX_OUTPUT_BYTES, limit_word);
        end else begin
            write_reg(REG_MAX_OUTPUT_BYTES, limit_word);
            write_reg(REG_DISPLAY_MODE, mode_word);
        end
        if ($urandom_range(0, 2) == 0) begin
            write_reg(CFG_IDX_W'($urandom_range(REG_NONE_LO, REG_NONE_HI)),
                      16'($urandom_range(0, 65535)));
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int          phase;
        int unsigned phase_left;
        phase = 0;
        phase_left = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain mode: controls pass, bad leads and cut sequences are replaced
        text_q = '{8'h00, CH_DEL, 8'hFF};
        send_text(1'b1);
        text_q = '{LEAD2_LO, 8'h80, LEAD3_LO, FOL_9F};
        send_text(1'b1);
        settle();
        write_reg(REG_DISPLAY_MODE, 16'h0001);
        write_reg(REG_MAX_OUTPUT_BYTES, 16'hFFFF);
        write_reg(REG_NONE_LO, 16'h0000);
        write_reg(REG_NONE_HI, 16'hFFFF);
        cfg_valid <= 1'b0;

        // display mode: controls, C1, surrogate, above range, a valid 4-byte char
        text_q = '{8'h01, LEAD2_LO, FOL_9F, LEAD_SURR, FOL_A0, LEAD4_HI, FOL_90,
                   LEAD4_LO, FOL_90, 8'h80, 8'h80};
        send_text(1'b1);
        settle();
        write_reg(REG_MAX_OUTPUT_BYTES, 16'h0000);
        cfg_valid <= 1'b0;
        text_q = '{8'h41};
        send_text(1'b1);
        settle();

        // mode flips while a sequence is held, then the limit truncates
        write_reg(REG_MAX_OUTPUT_BYTES, 16'd3);
        cfg_valid <= 1'b0;
        text_q = '{8'h41, 8'h42, 8'hE2};
        send_text(1'b0);
        settle();
        write_reg(REG_DISPLAY_MODE, 16'h0000);
        cfg_valid <= 1'b0;
        text_q = '{8'h82, 8'hAC};
        send_text(1'b0);
        settle();
        write_reg(REG_DISPLAY_MODE, 16'h0001);
        cfg_valid <= 1'b0;
        text_q = '{8'h43, 8'h44};
        send_text(1'b1);

        while (sent < ITEM_TARGET) begin
            if (phase_left == 0) begin
                settle();
                reconfigure(phase);
                phase++;
                phase_left = $urandom_range(20, 60);
            end
            if (sent >= ITEM_TARGET - CALM_ITEMS) calm <= 1'b1;
            build_string();
            phase_left = (text_q.size() >= phase_left) ? 0 : phase_left - text_q.size();
            send_text(1'b1);
        end
        settle();

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* files.f */
sv/usd_pkg.sv
sv/usd_front.sv
sv/usd_fifo.sv
sv/usd_back.sv
sv/utf8_display_sanitizer_core.sv
sv/usd_checker.sv
dv/usd_checker.sv
dv/tb_top.sv
